>>> hw/rtl/six_axis_step_pulse_generator_unit_defines.svh
// Assertion macros shared by the step pulse generator RTL.
`ifndef SIX_AXIS_STEP_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define SIX_AXIS_STEP_PULSE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define SASPG_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("saspg assertion failed");

// A condition that, once seen, implies another at the next clock edge.
`define SASPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("saspg assertion failed");

`else

`define SASPG_ASSERT(lbl, cond)
`define SASPG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/saspg_pkg.sv
// Package with widths, codes and payload types of the step pulse generator.
package saspg_pkg;

  localparam int NUM_AXES  = 6;
  localparam int AXIS_W    = 3;
  localparam int STEP_W    = 20;
  localparam int TIMER_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;

  localparam logic [TIMER_W-1:0] HALF_PERIOD_RST        = 24'd1500;
  localparam logic [TIMER_W-1:0] HOMING_HALF_PERIOD_RST = 24'd1500;
  localparam logic [STEP_W-1:0]  HOMING_STEP_COUNT_RST  = 20'd2880;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AXIS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_HALF_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_STEP_COUNT  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [AXIS_W-1:0] axis;
    logic              enable;
    logic              direction;
    logic [STEP_W-1:0] step_count;
    logic              start_req;
    logic              home_switch;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          out_byte_a;
    logic [7:0]          out_byte_b;
    logic [7:0]          out_byte_c;
    logic [7:0]          out_byte_d;
    logic [NUM_AXES-1:0] busy_axes;
    logic                homing_active;
  } out_item_t;

endpackage

>>> hw/rtl/six_axis_step_pulse_generator_unit.sv
// Six-axis step/direction pulse generator with homing on axis 0.
// A result passes the input register, then the result register, where it is held.
// Throughput: one item per cycle if not stalled; all six axes update in parallel in one logic pass.
// The input register stalls only while the result register is full and stalled.
// Reset (rst_n low, synchronous) clears all axis and homing state and loads the register defaults.
`include "six_axis_step_pulse_generator_unit_defines.svh"

module six_axis_step_pulse_generator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  saspg_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output saspg_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [saspg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [saspg_pkg::TIMER_W-1:0]          cfg_data
);

  typedef struct packed {
    logic                         enable;
    logic                         direction;
    logic                         pulse;
    logic                         running;
    logic                         start;
    logic [saspg_pkg::STEP_W-1:0]  steps;
    logic [saspg_pkg::TIMER_W-1:0] timer;
  } axis_state_t;

  function automatic logic [saspg_pkg::TIMER_W-1:0] nonzero_period(
    input logic [saspg_pkg::TIMER_W-1:0] p
  );
    return (p == '0) ? {{(saspg_pkg::TIMER_W-1){1'b0}}, 1'b1} : p;
  endfunction

  // One tick of a single axis: start a pulse, count down a phase, or end the move.
  function automatic axis_state_t axis_advance(
    input axis_state_t                   a,
    input logic [saspg_pkg::TIMER_W-1:0] per
  );
    axis_state_t                   r;
    logic [saspg_pkg::TIMER_W-1:0] t;
    logic [saspg_pkg::STEP_W-1:0]  s;
    r = a;
    t = a.timer;
    s = a.steps;
    if (!a.running) begin
      if (a.start) begin
        if (a.steps != '0) begin
          r.running = 1'b1;
          r.pulse   = 1'b1;
          r.timer   = per;
        end else begin
          r.start = 1'b0;
        end
      end
    end else begin
      if (a.timer != '0) begin
        t = a.timer - 1'b1;
      end
      r.timer = t;
      if (t == '0) begin
        if (a.pulse) begin
          r.pulse = 1'b0;
          r.timer = per;
        end else begin
          if (a.steps != '0) begin
            s = a.steps - 1'b1;
          end
          r.steps = s;
          if ((s == '0) || !a.start) begin
            r.running = 1'b0;
            r.start   = 1'b0;
          end else begin
            r.pulse = 1'b1;
            r.timer = per;
          end
        end
      end
    end
    return r;
  endfunction

  logic [saspg_pkg::TIMER_W-1:0] half_period_r;
  logic [saspg_pkg::TIMER_W-1:0] homing_half_period_r;
  logic [saspg_pkg::STEP_W-1:0]  homing_step_count_r;
  logic [saspg_pkg::TIMER_W-1:0] half_eff;
  logic [saspg_pkg::TIMER_W-1:0] homing_eff;

  saspg_pkg::in_item_t  item_r;
  logic                 item_vld_r;
  saspg_pkg::out_item_t out_r;
  saspg_pkg::out_item_t out_nxt;
  logic                 out_vld_r;
  logic                 can_adv;
  logic                 adv;

  axis_state_t ax_r   [saspg_pkg::NUM_AXES];
  axis_state_t ax_nxt [saspg_pkg::NUM_AXES];
  logic        homing_req_r;
  logic        homing_req_nxt;
  logic        homing_started_r;
  logic        homing_started_nxt;

  logic [saspg_pkg::NUM_AXES-1:0] running_vec;
  logic [saspg_pkg::NUM_AXES-1:0] pulse_vec;
  logic [saspg_pkg::NUM_AXES-1:0] timer_nz_vec;
  logic [saspg_pkg::NUM_AXES-1:0] busy_nxt;

  // Handshake: the result register frees itself when its transfer completes.
  assign can_adv   = !out_vld_r || !out_stall;
  assign adv       = item_vld_r && can_adv;
  assign in_stall  = item_vld_r && !can_adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign half_eff   = nonzero_period(half_period_r);
  assign homing_eff = nonzero_period(homing_half_period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r        <= saspg_pkg::HALF_PERIOD_RST;
      homing_half_period_r <= saspg_pkg::HOMING_HALF_PERIOD_RST;
      homing_step_count_r  <= saspg_pkg::HOMING_STEP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        saspg_pkg::CFG_HALF_PERIOD:        half_period_r        <= cfg_data;
        saspg_pkg::CFG_HOMING_HALF_PERIOD: homing_half_period_r <= cfg_data;
        saspg_pkg::CFG_HOMING_STEP_COUNT:
          homing_step_count_r <= cfg_data[saspg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < saspg_pkg::NUM_AXES; i++) begin
      ax_nxt[i] = ax_r[i];
    end
    homing_req_nxt     = homing_req_r;
    homing_started_nxt = homing_started_r;
    if (adv) begin
      unique case (item_r.kind)
        saspg_pkg::KIND_TICK: begin
          // The home switch is looked at before the homing move is (re)started.
          if (item_r.home_switch && homing_req_r) begin
            ax_nxt[0].start    = 1'b0;
            homing_req_nxt     = 1'b0;
            homing_started_nxt = 1'b0;
          end
          if (homing_req_nxt && !homing_started_nxt) begin
            homing_started_nxt  = 1'b1;
            ax_nxt[0].direction = 1'b1;
            ax_nxt[0].steps     = homing_step_count_r;
            ax_nxt[0].start     = 1'b1;
          end
          for (int i = 0; i < saspg_pkg::NUM_AXES; i++) begin
            ax_nxt[i] = axis_advance(ax_nxt[i],
                                     ((i == 0) && homing_started_nxt) ? homing_eff : half_eff);
          end
        end
        saspg_pkg::KIND_AXIS: begin
          if (item_r.axis < saspg_pkg::AXIS_W'(saspg_pkg::NUM_AXES)) begin
            ax_nxt[item_r.axis].enable    = item_r.enable;
            ax_nxt[item_r.axis].direction = item_r.direction;
            ax_nxt[item_r.axis].steps     = item_r.step_count;
            ax_nxt[item_r.axis].start     = item_r.start_req;
          end
        end
        saspg_pkg::KIND_HOME: homing_req_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < saspg_pkg::NUM_AXES; i++) begin
      busy_nxt[i]     = ax_nxt[i].running;
      running_vec[i]  = ax_r[i].running;
      pulse_vec[i]    = ax_r[i].pulse;
      timer_nz_vec[i] = (ax_r[i].timer != '0);
    end
    out_nxt.out_byte_a = {ax_nxt[0].direction, ax_nxt[2].direction,
                          ax_nxt[0].pulse, ax_nxt[2].pulse, 4'b0000};
    out_nxt.out_byte_b = {ax_nxt[1].enable, ax_nxt[4].enable,
                          ax_nxt[1].direction, ax_nxt[4].direction,
                          ax_nxt[1].pulse, ax_nxt[4].pulse,
                          ax_nxt[0].enable, ax_nxt[2].enable};
    out_nxt.out_byte_c = {1'b0, ax_nxt[3].direction, 1'b0, ax_nxt[3].pulse, 4'b0000};
    out_nxt.out_byte_d = {1'b0, ax_nxt[5].enable, 1'b0, ax_nxt[5].direction,
                          1'b0, ax_nxt[5].pulse, 1'b0, ax_nxt[3].enable};
    out_nxt.busy_axes     = busy_nxt;
    out_nxt.homing_active = homing_started_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < saspg_pkg::NUM_AXES; i++) begin
        ax_r[i] <= '0;
      end
      homing_req_r     <= 1'b0;
      homing_started_r <= 1'b0;
      item_vld_r       <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      for (int i = 0; i < saspg_pkg::NUM_AXES; i++) begin
        ax_r[i] <= ax_nxt[i];
      end
      homing_req_r     <= homing_req_nxt;
      homing_started_r <= homing_started_nxt;
      if (!in_stall) begin
        item_vld_r <= in_valid;
      end
      if (can_adv) begin
        out_vld_r <= item_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  `SASPG_ASSERT(a_running_timer_nz, (running_vec & ~timer_nz_vec) == '0)
  `SASPG_ASSERT(a_pulse_only_running, (pulse_vec & ~running_vec) == '0)
  `SASPG_ASSERT(a_started_has_request, !homing_started_r || homing_req_r)
  `SASPG_ASSERT_NEXT(a_held_item_kept, in_stall, item_vld_r && $stable(item_r))
  `SASPG_ASSERT_NEXT(a_non_tick_no_motion, adv && (item_r.kind != saspg_pkg::KIND_TICK),
                     $stable(running_vec) && $stable(pulse_vec))

endmodule
